>>> src/u8u16_pkg.sv
// Shared types and constants for the UTF-8 to UTF-16 decoder.
package u8u16_pkg;

    localparam int BYTE_W = 8;
    localparam int UNIT_W = 16;

    // Lead byte classification limits
    localparam logic [BYTE_W-1:0] ASCII_MAX   = 8'h7F;
    localparam logic [BYTE_W-1:0] LEAD2_MAX   = 8'hDF;
    localparam logic [BYTE_W-1:0] LEAD3_MAX   = 8'hEF;
    localparam logic [BYTE_W-1:0] NUL_BYTE    = 8'h00;

    // Payload masks
    localparam logic [BYTE_W-1:0] LEAD2_MASK  = 8'h1F;
    localparam logic [BYTE_W-1:0] LEAD3_MASK  = 8'h0F;
    localparam logic [BYTE_W-1:0] CONT_MASK   = 8'h3F;

    // Replacement unit for unsupported long sequences
    localparam logic [UNIT_W-1:0] UNIT_QMARK  = 16'h003F;
    localparam logic [UNIT_W-1:0] UNIT_NUL    = 16'h0000;

    // Bytes still owed to the open sequence
    typedef enum logic [1:0] {
        PEND_NONE = 2'd0,
        PEND_ONE  = 2'd1,
        PEND_TWO  = 2'd2
    } pending_t;

    // One decoded result as it moves from the decoder to the result register
    typedef struct packed {
        logic              emit;
        logic [UNIT_W-1:0] code_unit;
        logic              end_of_string;
    } result_t;

endpackage

>>> src/u8u16_in_stage.sv
// Input register: captures one byte per transaction and holds it until decoded.
module u8u16_in_stage (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          data_valid,
    output logic                          data_stall,
    input  logic [u8u16_pkg::BYTE_W-1:0]  data_byte,
    input  logic                          advance,
    output logic                          held_valid,
    output logic [u8u16_pkg::BYTE_W-1:0]  held_byte
);
    import u8u16_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    logic [BYTE_W-1:0] byte_reg;
    logic              accept;

    // Stall while a byte is held and cannot move on this cycle
    assign data_stall = valid_reg && !advance;
    assign accept     = data_valid && !data_stall;

    always_comb
    begin
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    // Hold the valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Capture the byte on each accepted transaction
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg <= data_byte;
        end
    end

    assign held_valid = valid_reg;
    assign held_byte  = byte_reg;

endmodule

>>> src/u8u16_decode.sv
// Sequence decoder: keeps the open UTF-8 sequence and forms one code unit per completed sequence.
module u8u16_decode (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          fire,
    input  logic [u8u16_pkg::BYTE_W-1:0]  byte_in,
    output u8u16_pkg::result_t            result
);
    import u8u16_pkg::*;

    logic [BYTE_W-1:0] lead_reg;
    logic [BYTE_W-1:0] lead_next;
    logic [BYTE_W-1:0] first_cont_reg;
    logic [BYTE_W-1:0] first_cont_next;
    pending_t          pending_reg;
    pending_t          pending_next;
    logic [UNIT_W-1:0] unit_two;
    logic [UNIT_W-1:0] unit_three;
    logic [BYTE_W-1:0] lead_low2;
    logic [BYTE_W-1:0] lead_low3;
    logic [BYTE_W-1:0] cont_low1;
    logic [BYTE_W-1:0] cont_low2;

    // Assemble the two- and three-byte code units
    assign lead_low2  = lead_reg & LEAD2_MASK;
    assign lead_low3  = lead_reg & LEAD3_MASK;
    assign cont_low1  = first_cont_reg & CONT_MASK;
    assign cont_low2  = byte_in & CONT_MASK;
    assign unit_two   = {5'd0, lead_low2[4:0], cont_low2[5:0]};
    assign unit_three = {lead_low3[3:0], cont_low1[5:0], cont_low2[5:0]};

    // Decide the next state and the result for the current byte
    always_comb
    begin
        lead_next            = lead_reg;
        first_cont_next      = first_cont_reg;
        pending_next         = PEND_NONE;
        result.emit          = 1'b0;
        result.code_unit     = UNIT_NUL;
        result.end_of_string = 1'b0;
        case (pending_reg)
            PEND_TWO:
            begin
                if (lead_reg <= LEAD2_MAX)
                begin
                    result.emit      = 1'b1;
                    result.code_unit = unit_two;
                end
                else
                begin
                    first_cont_next = byte_in;
                    pending_next    = PEND_ONE;
                end
            end
            PEND_ONE:
            begin
                result.emit = 1'b1;
                if (lead_reg <= LEAD2_MAX)
                begin
                    result.code_unit = unit_two;
                end
                else if (lead_reg <= LEAD3_MAX)
                begin
                    result.code_unit = unit_three;
                end
                else
                begin
                    result.code_unit = UNIT_QMARK;
                end
            end
            default:
            begin
                if (byte_in == NUL_BYTE)
                begin
                    result.emit          = 1'b1;
                    result.end_of_string = 1'b1;
                end
                else if (byte_in <= ASCII_MAX)
                begin
                    result.emit      = 1'b1;
                    result.code_unit = {8'd0, byte_in};
                end
                else
                begin
                    lead_next    = byte_in;
                    pending_next = (byte_in <= LEAD2_MAX) ? PEND_ONE : PEND_TWO;
                end
            end
        endcase
    end

    // Advance the sequence state when a byte is consumed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lead_reg       <= '0;
            first_cont_reg <= '0;
            pending_reg    <= PEND_NONE;
        end
        else if (fire)
        begin
            lead_reg       <= lead_next;
            first_cont_reg <= first_cont_next;
            pending_reg    <= pending_next;
        end
    end

endmodule

>>> src/u8u16_out_stage.sv
// Result register: holds one code unit until the downstream side takes it.
module u8u16_out_stage (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          load,
    input  u8u16_pkg::result_t            result,
    output logic                          can_load,
    output logic                          unit_valid,
    input  logic                          unit_stall,
    output logic [u8u16_pkg::UNIT_W-1:0]  code_unit,
    output logic                          end_of_string
);
    import u8u16_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    logic [UNIT_W-1:0] unit_reg;
    logic              eos_reg;
    logic              take;

    // Register is free when empty or being drained this cycle
    assign can_load = !valid_reg || !unit_stall;
    assign take     = load && result.emit;

    always_comb
    begin
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (!unit_stall)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    // Hold the valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Capture the payload of a new result
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            unit_reg <= result.code_unit;
            eos_reg  <= result.end_of_string;
        end
    end

    assign unit_valid    = valid_reg;
    assign code_unit     = unit_reg;
    assign end_of_string = eos_reg;

endmodule

>>> src/utf8_to_utf16_decoder.sv
// Top level of the streaming UTF-8 to UTF-16 decoder.
//
// Takes one UTF-8 byte per transaction and returns one 16-bit UTF-16 code
// unit for each completed sequence: ASCII bytes pass through, two- and
// three-byte sequences are assembled, leads 0xF0 and above swallow two more
// bytes and give '?' (0x003F), and a zero byte outside a sequence gives a zero
// unit with end_of_string set. Continuation bytes are not checked. A byte
// passes from acceptance through the input register, the decode logic and the
// result register to its result, and a new byte is accepted every cycle while
// unit_stall is low; the throughput of one byte per clock is set by the
// combinational decode between the two registers. Bytes that only extend a
// sequence produce no output transaction.
module utf8_to_utf16_decoder (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          data_valid,
    output logic                          data_stall,
    input  logic [u8u16_pkg::BYTE_W-1:0]  data_byte,
    output logic                          unit_valid,
    input  logic                          unit_stall,
    output logic [u8u16_pkg::UNIT_W-1:0]  code_unit,
    output logic                          end_of_string
);
    import u8u16_pkg::*;

    logic              held_valid;
    logic [BYTE_W-1:0] held_byte;
    logic              can_load;
    logic              advance;
    logic              fire;
    result_t           result;

    // Move the held byte through the decoder when the result register is free
    assign advance = can_load;
    assign fire    = held_valid && advance;

    u8u16_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .data_valid (data_valid),
        .data_stall (data_stall),
        .data_byte  (data_byte),
        .advance    (advance),
        .held_valid (held_valid),
        .held_byte  (held_byte)
    );

    u8u16_decode u_decode (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (fire),
        .byte_in (held_byte),
        .result  (result)
    );

    u8u16_out_stage u_out_stage (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (fire),
        .result        (result),
        .can_load      (can_load),
        .unit_valid    (unit_valid),
        .unit_stall    (unit_stall),
        .code_unit     (code_unit),
        .end_of_string (end_of_string)
    );

`ifndef SYNTHESIS
    // A stalled input side means a byte is waiting in the input register
    assert property (@(posedge clk) disable iff (!rst_n)
        data_stall |-> held_valid)
        else $error("input stalled with empty input register");

    // No byte is decoded while a result is blocked downstream
    assert property (@(posedge clk) disable iff (!rst_n)
        (unit_valid && unit_stall) |-> !fire)
        else $error("byte decoded while result register blocked");

    // The terminator always carries a zero unit
    assert property (@(posedge clk) disable iff (!rst_n)
        (unit_valid && end_of_string) |-> (code_unit == UNIT_NUL))
        else $error("terminator with nonzero code unit");

    // A decoded result lands in the result register on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && result.emit) |=> unit_valid)
        else $error("decoded result lost");
`endif

endmodule

>>> bench/utf8_to_utf16_decoder_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the streaming UTF-8 to UTF-16 decoder.
module utf8_to_utf16_decoder_tb;
    import u8u16_pkg::*;

    localparam int CLK_HALF     = 2;
    localparam int RESET_CYCLES = 7;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASE_BYTES  = 450;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        logic [UNIT_W-1:0] code_unit;
        logic              end_of_string;
    } unit_t;

    logic              clk        = 1'b0;
    logic              rst_n      = 1'b0;
    logic              data_valid = 1'b0;
    logic [BYTE_W-1:0] data_byte  = '0;
    logic              unit_stall = 1'b0;
    logic              data_stall;
    logic              unit_valid;
    logic [UNIT_W-1:0] code_unit;
    logic              end_of_string;

    // Decoder shadow state, kept in step with accepted bytes
    pending_t          seq_pending    = PEND_NONE;
    logic [BYTE_W-1:0] seq_lead       = '0;
    logic [BYTE_W-1:0] seq_first_cont = '0;

    unit_t owed_units[$];
    int    mismatches     = 0;
    int    cycles         = 0;
    int    send_idle_pct  = 0;
    int    unit_stall_pct = 0;

    utf8_to_utf16_decoder dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .data_valid    (data_valid),
        .data_stall    (data_stall),
        .data_byte     (data_byte),
        .unit_valid    (unit_valid),
        .unit_stall    (unit_stall),
        .code_unit     (code_unit),
        .end_of_string (end_of_string)
    );

    // Generate the clock
    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // Advance the shadow decoder by one byte; return 1 when a unit is due
    function automatic bit decode_byte(input logic [BYTE_W-1:0] b, output unit_t u);
        bit emit;
        emit = 1'b0;
        u    = '{code_unit: UNIT_NUL, end_of_string: 1'b0};
        case (seq_pending)
            PEND_TWO:
            begin
                seq_first_cont = b;
                seq_pending    = PEND_ONE;
            end
            PEND_ONE:
            begin
                seq_pending = PEND_NONE;
                emit        = 1'b1;
                if (seq_lead <= LEAD2_MAX)
                    u.code_unit = {5'b0, seq_lead[4:0], b[5:0]};
                else if (seq_lead <= LEAD3_MAX)
                    u.code_unit = {seq_lead[3:0], seq_first_cont[5:0], b[5:0]};
                else
                    u.code_unit = UNIT_QMARK;
            end
            default:
            begin
                seq_pending = PEND_NONE;
                if (b == NUL_BYTE)
                begin
                    u.end_of_string = 1'b1;
                    emit            = 1'b1;
                end
                else if (b <= ASCII_MAX)
                begin
                    u.code_unit = {8'h00, b};
                    emit        = 1'b1;
                end
                else
                begin
                    seq_lead    = b;
                    seq_pending = (b <= LEAD2_MAX) ? PEND_ONE : PEND_TWO;
                end
            end
        endcase
        return emit;
    endfunction

    // Check output transactions, predict from input transactions, drive stall
    always @(posedge clk)
    begin : unit_monitor
        unit_t got;
        unit_t want;
        unit_t predicted;
        if (rst_n)
        begin
            if (unit_valid && !unit_stall)
            begin
                got = '{code_unit: code_unit, end_of_string: end_of_string};
                if (owed_units.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("unexpected unit: code_unit=%h end_of_string=%b",
                                 got.code_unit, got.end_of_string);
                end
                else
                begin
                    want = owed_units.pop_front();
                    if (got.code_unit !== want.code_unit ||
                        got.end_of_string !== want.end_of_string)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("mismatch: code_unit exp %h got %h, eos exp %b got %b",
                                     want.code_unit, got.code_unit,
                                     want.end_of_string, got.end_of_string);
                    end
                end
            end
            if (data_valid && !data_stall)
                if (decode_byte(data_byte, predicted))
                    owed_units.push_back(predicted);
        end
        unit_stall <= ($urandom_range(99) < unit_stall_pct);
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL utf8_to_utf16_decoder");
            $finish;
        end
    end

    // Offer one byte, with a random gap first, and hold it until taken
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        if ($urandom_range(99) < send_idle_pct)
        begin
            data_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        data_valid <= 1'b1;
        data_byte  <= b;
        @(posedge clk);
        while (data_stall)
            @(posedge clk);
    endtask

    // Hold off the sender until every predicted unit has come back
    task automatic wait_for_units();
        data_valid <= 1'b0;
        @(posedge clk);
        while (owed_units.size() != 0)
            @(posedge clk);
    endtask

    // Pick a continuation byte: mostly well formed, sometimes any value
    function automatic logic [BYTE_W-1:0] cont_byte();
        if ($urandom_range(9) == 0)
            return 8'($urandom_range(255));
        return 8'($urandom_range(8'hBF, 8'h80));
    endfunction

    task automatic test_ascii_and_terminator();
        send_byte(8'h01);
        send_byte(8'h41);
        send_byte(8'h7F);
        send_byte(8'h00);
    endtask

    // Two-byte sequences, including a stray continuation used as a lead
    task automatic test_two_byte();
        send_byte(8'hC2);
        send_byte(8'hA9);
        send_byte(8'hDF);
        send_byte(8'hFF);
        send_byte(8'h80);
        send_byte(8'h00);
        send_byte(8'hBF);
        send_byte(8'hBF);
    endtask

    // Three-byte sequences, including zero bytes consumed as continuations
    task automatic test_three_byte();
        send_byte(8'hE2);
        send_byte(8'h82);
        send_byte(8'hAC);
        send_byte(8'hEF);
        send_byte(8'hBF);
        send_byte(8'hBF);
        send_byte(8'hE0);
        send_byte(8'h00);
        send_byte(8'h00);
    endtask

    // Leads of 0xF0 and above swallow two bytes and give a question mark
    task automatic test_long_leads();
        send_byte(8'hF0);
        send_byte(8'h9F);
        send_byte(8'h98);
        send_byte(8'hFF);
        send_byte(8'hFF);
        send_byte(8'h40);
        send_byte(8'h00);
        wait_for_units();
    endtask

    // Mostly well-formed sequences with random content, plus noise
    task automatic test_random_phase(input int idle_pct, input int stall_pct,
                                     input int n_bytes);
        int                sent;
        int                kind;
        logic [BYTE_W-1:0] seq_bytes[$];
        send_idle_pct  = idle_pct;
        unit_stall_pct = stall_pct;
        sent           = 0;
        while (sent < n_bytes)
        begin
            seq_bytes.delete();
            kind = $urandom_range(99);
            if (kind < 28)
                seq_bytes.push_back(8'($urandom_range(8'h7F, 8'h01)));
            else if (kind < 48)
            begin
                seq_bytes.push_back(8'($urandom_range(8'hDF, 8'hC0)));
                seq_bytes.push_back(cont_byte());
            end
            else if (kind < 68)
            begin
                seq_bytes.push_back(8'($urandom_range(8'hEF, 8'hE0)));
                seq_bytes.push_back(cont_byte());
                seq_bytes.push_back(cont_byte());
            end
            else if (kind < 78)
            begin
                seq_bytes.push_back(8'($urandom_range(8'hFF, 8'hF0)));
                seq_bytes.push_back(cont_byte());
                seq_bytes.push_back(cont_byte());
            end
            else if (kind < 84)
                seq_bytes.push_back(NUL_BYTE);
            else if (kind < 91)
            begin
                seq_bytes.push_back(8'($urandom_range(8'hBF, 8'h80)));
                seq_bytes.push_back(cont_byte());
            end
            else
                seq_bytes.push_back(8'($urandom_range(255)));
            foreach (seq_bytes[i])
                send_byte(seq_bytes[i]);
            sent += seq_bytes.size();
        end
        wait_for_units();
    endtask

    // Run the tests in turn
    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_ascii_and_terminator();
        test_two_byte();
        test_three_byte();
        test_long_leads();

        test_random_phase(0, 0, PHASE_BYTES);
        test_random_phase(61, 0, PHASE_BYTES);
        test_random_phase(0, 61, PHASE_BYTES);
        test_random_phase(13, 13, PHASE_BYTES);

        wait_for_units();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("PASS utf8_to_utf16_decoder");
        else
            $display("FAIL utf8_to_utf16_decoder");
        $finish;
    end

endmodule
